[rtl/core/ghp_pkg.sv]
// Shared types and codes for the generational handle pool.
// No dependencies; imported by the controller, the datapath and the top level.
package ghp_pkg;

  localparam int GEN_W    = 16;
  localparam int SLOT_W   = 16;
  localparam int HANDLE_W = GEN_W + SLOT_W;

  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_LOOKUP  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // per-slot table entry: live flag plus current generation
  typedef struct packed {
    logic             live;
    logic [GEN_W-1:0] gen;
  } tab_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch the input word, issue first memory read
    logic pop;     // take a slot off the free stack, issue table read
    logic exec;    // resolve, write back, load the output register
  } ghp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic alloc_go;  // incoming word is an allocate and the stack is not empty
    logic out_free;  // output register can take a word this cycle
  } ghp_sts_t;

endpackage

[rtl/core/ghp_ctrl.sv]
// Sequencing state machine for the generational handle pool.
// Depends on ghp_pkg for the command and status structs.
module ghp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ghp_pkg::ghp_sts_t sts,
  output ghp_pkg::ghp_cmd_t cmd
);
  import ghp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.pop    = 1'b0;
    cmd.exec   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.alloc_go ? S_POP : S_EXEC;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // hold here while the previous result is still unclaimed
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/ghp_dp.sv]
// Datapath of the generational handle pool: free stack, slot table, output register.
// Depends on ghp_pkg; driven by ghp_ctrl through ghp_cmd_t.
module ghp_dp #(
  parameter int NUM_SLOTS = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ghp_pkg::ghp_cmd_t              cmd,
  output ghp_pkg::ghp_sts_t              sts,
  input  logic [1:0]                     in_func,
  input  logic [ghp_pkg::HANDLE_W-1:0]   in_handle,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [ghp_pkg::HANDLE_W-1:0]   out_new_handle,
  output logic [ghp_pkg::SLOT_W-1:0]     out_slot
);
  import ghp_pkg::*;

  localparam int TW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS + 1) : 1;  // slot / count width
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;      // stack index width

  // slot table indexed by slot, stack indexed by depth
  tab_entry_t         tab_mem [0:NUM_SLOTS];
  logic [SLOT_W-1:0]  stk_mem [0:NUM_SLOTS-1];

  // control state
  logic [TW-1:0] top_r;    // free slots on the stack
  logic [TW-1:0] used_r;   // slots handed out at least once (1..used_r touched)
  logic          out_valid_r;

  // payload
  logic [1:0]          func_r;
  logic [HANDLE_W-1:0] hdl_r;
  logic                full_r;
  logic [TW-1:0]       slot_r;
  logic                tvalid_r;
  tab_entry_t          tab_q;
  logic [SLOT_W-1:0]   stk_q;
  logic [1:0]          status_r;
  logic [HANDLE_W-1:0] new_handle_r;
  logic [SLOT_W-1:0]   out_slot_r;

  logic                acc_range_ok;
  logic [TW-1:0]       acc_addr;
  logic                pop_fresh;
  logic [TW-1:0]       pop_slot;
  logic [TW-1:0]       tab_ra;
  logic [SW-1:0]       stk_ra;
  logic [GEN_W-1:0]    gen_old;
  logic [GEN_W-1:0]    gen_inc;
  logic                match;
  logic                tab_we;
  tab_entry_t          tab_wd;
  logic                stk_we;
  logic [1:0]          status_nxt;
  logic [HANDLE_W-1:0] new_handle_nxt;
  logic [SLOT_W-1:0]   slot_nxt;

  assign sts.alloc_go = (in_func == FN_ALLOC) && (top_r != '0);
  assign sts.out_free = !out_valid_r || !out_stall;

  // handle slot must be 1..NUM_SLOTS; out of range reads entry 0
  assign acc_range_ok = (in_handle[SLOT_W-1:0] != '0) &&
                        (in_handle[SLOT_W-1:0] <= SLOT_W'(NUM_SLOTS));
  assign acc_addr     = acc_range_ok ? in_handle[TW-1:0] : '0;

  // stack entries below NUM_SLOTS-used_r still hold their reset contents
  assign pop_fresh = ({1'b0, top_r} + {1'b0, used_r}) <= (TW+1)'(NUM_SLOTS);
  assign pop_slot  = pop_fresh ? (used_r + TW'(1)) : stk_q[TW-1:0];

  assign tab_ra = cmd.pop ? pop_slot : acc_addr;
  assign stk_ra = SW'(top_r - TW'(1));

  // resolve against the registered table entry; untouched slots read as zero
  always_comb begin
    gen_old = tvalid_r ? tab_q.gen : '0;
    gen_inc = gen_old + GEN_W'(1);
    if (gen_inc == '0) begin
      gen_inc = GEN_W'(1);
    end
    match = tvalid_r && tab_q.live && (tab_q.gen == hdl_r[HANDLE_W-1:SLOT_W]);

    status_nxt     = ST_INVALID;
    new_handle_nxt = '0;
    slot_nxt       = '0;
    tab_we         = 1'b0;
    stk_we         = 1'b0;
    tab_wd.live    = 1'b0;
    tab_wd.gen     = gen_old;
    case (func_r)
      FN_ALLOC: begin
        if (full_r) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt     = ST_OK;
          new_handle_nxt = {gen_inc, SLOT_W'(slot_r)};
          slot_nxt       = SLOT_W'(slot_r);
          tab_we         = cmd.exec;
          tab_wd.live    = 1'b1;
          tab_wd.gen     = gen_inc;
        end
      end
      FN_RELEASE: begin
        if (match) begin
          status_nxt = ST_OK;
          slot_nxt   = SLOT_W'(slot_r);
          tab_we     = cmd.exec;
          stk_we     = cmd.exec && (top_r < TW'(NUM_SLOTS));
        end
      end
      FN_LOOKUP: begin
        if (match) begin
          status_nxt = ST_OK;
          slot_nxt   = SLOT_W'(slot_r);
        end
      end
      default: status_nxt = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= TW'(NUM_SLOTS);
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.pop) begin
        top_r <= top_r - TW'(1);
        if (pop_fresh) begin
          used_r <= used_r + TW'(1);
        end
      end else if (stk_we) begin
        top_r <= top_r + TW'(1);
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r   <= in_func;
      hdl_r    <= in_handle;
      full_r   <= (top_r == '0);
      slot_r   <= acc_addr;
      tvalid_r <= acc_range_ok && (acc_addr <= used_r);
    end else if (cmd.pop) begin
      slot_r   <= pop_slot;
      tvalid_r <= !pop_fresh;
    end
    if (cmd.exec) begin
      status_r     <= status_nxt;
      new_handle_r <= new_handle_nxt;
      out_slot_r   <= slot_nxt;
    end
  end

  // slot table: one read, one write port
  always_ff @(posedge clk) begin
    if (cmd.accept || cmd.pop) begin
      tab_q <= tab_mem[tab_ra];
    end
    if (tab_we) begin
      tab_mem[slot_r] <= tab_wd;
    end
  end

  // free stack: one read, one write port
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      stk_q <= stk_mem[stk_ra];
    end
    if (stk_we) begin
      stk_mem[top_r[SW-1:0]] <= SLOT_W'(slot_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_new_handle = new_handle_r;
  assign out_slot       = out_slot_r;

endmodule

[rtl/core/generational_handle_pool_top.sv]
// Generational handle pool, top level: joins the controller and the datapath.
// Depends on ghp_pkg, ghp_ctrl and ghp_dp.
//
// Hands out 32-bit handles (generation in 31:16, slot in 15:0) over NUM_SLOTS slots
// numbered from 1, checks them on lookup and takes them back on release. Each input
// word gives one result word. Only a successful allocate passes a pop state between
// accept and execute: the free stack read and then the slot table read each go
// through a registered memory port before the write-back. A new word is taken while
// the last result is still waiting on the output. No clearing pass runs after reset;
// a fill count of slots handed out stands in for the reset contents of both memories.
module generational_handle_pool_top #(
  parameter int NUM_SLOTS = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_func,
  input  logic [ghp_pkg::HANDLE_W-1:0]   in_handle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [ghp_pkg::HANDLE_W-1:0]   out_new_handle,
  output logic [ghp_pkg::SLOT_W-1:0]     out_slot
);
  import ghp_pkg::*;

  ghp_cmd_t cmd;
  ghp_sts_t sts;

  ghp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ghp_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_handle      (in_handle),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_new_handle (out_new_handle),
    .out_slot       (out_slot)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in flight");

  a_pop_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> $past(cmd.accept))
    else $error("stack pop without a preceding accept");

  a_exec_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("result word not presented after execute");

  a_ok_alloc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_new_handle != '0) |-> (out_status == ST_OK) && (out_slot != '0))
    else $error("handle issued with bad status or slot");

endmodule
